FILE: hw/rtl/mac_al_pkg.sv
// MAC allowlist table: shared constants, state encoding and the
// controller/datapath command and status bundles. No dependencies.
package mac_al_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAC_W       = 48;
    localparam int PORT_W      = 4;
    localparam int CNT_W       = 7;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_CHECK,
        ST_RESULT
    } mac_al_state_t;

    typedef struct packed {
        logic load_item;
        logic scan_rd;
        logic out_load;
    } mac_al_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic port_match;
        logic table_empty;
        logic scan_last;
        logic out_free;
    } mac_al_sts_t;

endpackage

FILE: hw/rtl/mac_al_ctrl.sv
// MAC allowlist controller: sequences load, table scan and result.
// Depends on mac_al_pkg.
module mac_al_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    output mac_al_pkg::mac_al_cmd_t  cmd,
    input  mac_al_pkg::mac_al_sts_t  sts
);
    import mac_al_pkg::*;

    mac_al_state_t state_reg;
    mac_al_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (sts.is_lookup && sts.port_match && !sts.table_empty)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mac_al_dp.sv
// MAC allowlist datapath: request registers, address table memory,
// scan compare, entry count, monitored port and result register.
// Depends on mac_al_pkg.
module mac_al_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [mac_al_pkg::PORT_W-1:0]         cfg_wr_data,
    input  logic [mac_al_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mac_al_pkg::M_TDATA_W-1:0]      m_tdata,
    input  mac_al_pkg::mac_al_cmd_t               cmd,
    output mac_al_pkg::mac_al_sts_t               sts
);
    import mac_al_pkg::*;

    logic [MAC_W-1:0]     mem [TABLE_DEPTH];

    logic                 op_reg;
    logic [MAC_W-1:0]     mac_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [PORT_W-1:0]    mon_port_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic [MAC_W-1:0]     rd_data_reg;
    logic                 cmp_vld_reg;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 out_vld_reg;
    logic                 out_found_reg;
    logic                 out_status_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic                 full;
    logic                 wr_en;
    logic [CNT_W-1:0]     last_idx;

    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en    = cmd.out_load && (op_reg == CMD_INSERT) && !full;
    assign last_idx = count_reg - CNT_W'(1);

    assign count_next = wr_en ? count_reg + CNT_W'(1) : count_reg;
    assign hit_next   = hit_reg || (cmp_vld_reg && (rd_data_reg == mac_reg));

    assign sts.is_lookup   = (op_reg == CMD_LOOKUP);
    assign sts.port_match  = (port_reg == mon_port_reg);
    assign sts.table_empty = (count_reg == '0);
    assign sts.scan_last   = (CNT_W'(rd_addr_reg) == last_idx);
    assign sts.out_free    = !out_vld_reg || m_tready;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= s_tuser;
            mac_reg  <= s_tdata[MAC_W-1:0];
            port_reg <= s_tdata[MAC_W +: PORT_W];
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= mac_reg;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_port_reg <= '0;
            count_reg    <= '0;
            rd_addr_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mon_port_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            cmp_vld_reg <= cmd.scan_rd;
            if (cmd.load_item)
            begin
                rd_addr_reg <= '0;
                hit_reg     <= 1'b0;
            end
            else
            begin
                hit_reg <= hit_next;
                if (cmd.scan_rd)
                begin
                    rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg  <= (op_reg == CMD_LOOKUP) && hit_reg;
            out_status_reg <= ((op_reg == CMD_INSERT) && full) ? STATUS_FULL : STATUS_OK;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - CNT_W - 2){1'b0}}, out_count_reg,
                       out_status_reg, out_found_reg};

endmodule

FILE: hw/rtl/mac_allowlist_table_core.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: cmd; tdata: mac, port
// m_*       out  m_tvalid/m_tready  tdata: found, status, entry_count
// cfg_*     in   cfg_wr_en          cfg_wr_data: monitored_port
//
// One request at a time. Inserts and non-scanning lookups skip the table scan.
// A lookup on the monitored port scans all stored entries, one table
// entry read per cycle through the single memory read port.
// The result register lets the next request enter while a result waits.
// Reset clears count, monitored port and handshake state; table contents
// are not cleared. A stalled output holds the block in its result state.
// Top level of the MAC allowlist table; uses mac_al_pkg, mac_al_ctrl, mac_al_dp.
module mac_allowlist_table_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [mac_al_pkg::PORT_W-1:0]         cfg_wr_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mac_al_pkg::S_TDATA_W-1:0]      s_tdata,  // mac[47:0], port[51:48]
    input  logic                                  s_tuser,  // cmd[0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mac_al_pkg::M_TDATA_W-1:0]      m_tdata   // found[0], status[1], count[8:2]
);
    import mac_al_pkg::*;

    mac_al_cmd_t cmd;
    mac_al_sts_t sts;

    mac_al_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mac_al_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[CNT_W+1:2] <= CNT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> (!sts.table_empty && sts.is_lookup))
        else $error("scan read without a lookup on a filled table");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");

endmodule
